### hdl/itda_pkg.sv
// Shared types and constants for the integer to decimal ASCII converter.
`timescale 1ns / 1ps

package itda_pkg;

    localparam int MAX_DIGITS  = 10;
    localparam int DIGIT_W     = 4;
    localparam int CNT_W       = 4;
    localparam int CHAR_W      = 7;
    localparam int VALUE_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    // One converted number: sign, digit count, digits with the most significant at index 0
    typedef struct packed {
        logic                                neg;
        logic [CNT_W-1:0]                    count;
        logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits;
    } conv_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_CONV,
        FRONT_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_SIGN,
        BACK_DIGIT
    } back_state_t;

endpackage

### hdl/itda_front.sv
// Front end: accepts a value, splits off the sign and peels decimal digits one per cycle.
`timescale 1ns / 1ps

module itda_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [31:0]          value,
    output logic                        busy,
    input  itda_pkg::queue_status_t     q_status,
    output logic                        push,
    output itda_pkg::conv_entry_t       push_entry
);
    import itda_pkg::*;

    front_state_t                        state_reg, state_next;
    logic [VALUE_W-1:0]                  mag_reg, mag_next;
    logic                                neg_reg, neg_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits_reg, digits_next;

    logic [2*VALUE_W-1:0]                prod_w;
    logic [VALUE_W-1:0]                  quot_w;
    logic [VALUE_W-1:0]                  times10_w;
    logic [VALUE_W-1:0]                  rem_w;
    logic                                last_digit_w;

    // Divide by ten through the reciprocal, remainder by shift-add
    assign prod_w       = (2*VALUE_W)'(mag_reg) * (2*VALUE_W)'(RECIP_10);
    assign quot_w       = VALUE_W'(prod_w >> RECIP_SHIFT);
    assign times10_w    = (quot_w << 3) + (quot_w << 1);
    assign rem_w        = mag_reg - times10_w;
    assign last_digit_w = (quot_w == '0) || (count_reg == CNT_W'(MAX_DIGITS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FRONT_IDLE:
            begin
                if (start)
                    state_next = FRONT_CONV;
            end
            FRONT_CONV:
            begin
                if (last_digit_w)
                    state_next = FRONT_PUSH;
            end
            FRONT_PUSH:
            begin
                if (!q_status.full)
                    state_next = FRONT_IDLE;
            end
            default: state_next = FRONT_IDLE;
        endcase
    end

    always_comb
    begin
        busy = 1'b1;
        push = 1'b0;
        unique case (state_reg)
            FRONT_IDLE: busy = 1'b0;
            FRONT_CONV: busy = 1'b1;
            FRONT_PUSH: push = !q_status.full;
            default:    busy = 1'b1;
        endcase
    end

    always_comb
    begin
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        count_next  = count_reg;
        digits_next = digits_reg;
        if (state_reg == FRONT_IDLE && start)
        begin
            neg_next    = value[VALUE_W-1];
            mag_next    = value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(value)) : $unsigned(value);
            count_next  = '0;
            digits_next = '0;
        end
        else if (state_reg == FRONT_CONV)
        begin
            // newest digit is the most significant so far: shift it in at index 0
            mag_next    = quot_w;
            count_next  = count_reg + CNT_W'(1);
            digits_next = {digits_reg[MAX_DIGITS-2:0], rem_w[DIGIT_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FRONT_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        count_reg  <= count_next;
        digits_reg <= digits_next;
    end

    assign push_entry.neg    = neg_reg;
    assign push_entry.count  = count_reg;
    assign push_entry.digits = digits_reg;

    a_conv_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FRONT_CONV |-> count_reg < CNT_W'(MAX_DIGITS))
        else $error("front digit count ran past the maximum");

    a_push_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != '0 && count_reg <= CNT_W'(MAX_DIGITS))
        else $error("front pushed an entry without a valid digit count");

    a_conv_reaches_push: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FRONT_CONV && last_digit_w |=> state_reg == FRONT_PUSH)
        else $error("front did not move to push after the last digit");

endmodule

### hdl/itda_queue.sv
// Short queue of converted numbers between the front and back ends.
`timescale 1ns / 1ps

module itda_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  itda_pkg::conv_entry_t       push_entry,
    input  logic                        pop,
    output itda_pkg::conv_entry_t       head,
    output itda_pkg::queue_status_t     q_status
);
    import itda_pkg::*;

    conv_entry_t        entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    assign head           = entries_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

endmodule

### hdl/itda_back.sv
// Back end: emits the sign and digits of each queued number, one character per cycle.
`timescale 1ns / 1ps

module itda_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  itda_pkg::queue_status_t     q_status,
    input  itda_pkg::conv_entry_t       head,
    output logic                        pop,
    output logic                        strobe,
    output logic [6:0]                  ascii_char,
    output logic                        last
);
    import itda_pkg::*;

    back_state_t                         state_reg, state_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits_reg, digits_next;
    logic                                final_w;

    assign final_w = (state_reg == BACK_DIGIT) && (count_reg == CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!q_status.empty)
                    state_next = head.neg ? BACK_SIGN : BACK_DIGIT;
            end
            BACK_SIGN:
                state_next = BACK_DIGIT;
            BACK_DIGIT:
            begin
                // chain straight into the next number when one is waiting
                if (final_w)
                begin
                    if (!q_status.empty)
                        state_next = head.neg ? BACK_SIGN : BACK_DIGIT;
                    else
                        state_next = BACK_IDLE;
                end
            end
            default: state_next = BACK_IDLE;
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        strobe     = 1'b0;
        ascii_char = CHAR_ZERO;
        last       = 1'b0;
        unique case (state_reg)
            BACK_IDLE:
                pop = !q_status.empty;
            BACK_SIGN:
            begin
                strobe     = 1'b1;
                ascii_char = CHAR_MINUS;
            end
            BACK_DIGIT:
            begin
                strobe     = 1'b1;
                ascii_char = CHAR_ZERO + CHAR_W'(digits_reg[0]);
                last       = final_w;
                pop        = final_w && !q_status.empty;
            end
            default: pop = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        digits_next = digits_reg;
        if (pop)
        begin
            count_next  = head.count;
            digits_next = head.digits;
        end
        else if (state_reg == BACK_DIGIT)
        begin
            count_next  = count_reg - CNT_W'(1);
            digits_next = {DIGIT_W'(0), digits_reg[MAX_DIGITS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BACK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        digits_reg <= digits_next;
    end

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BACK_DIGIT |-> digits_reg[0] <= DIGIT_W'(9))
        else $error("back emitting a digit above nine");

    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BACK_DIGIT |-> count_reg != '0)
        else $error("back emitting with no digits left");

    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BACK_SIGN |=> state_reg == BACK_DIGIT)
        else $error("sign not followed by a digit");

endmodule

### hdl/int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
//
// Input: drive value and raise start; the transfer happens at the clock edge where
// start is high and busy is low. busy stays high while the front end divides the
// magnitude by ten, one digit per cycle, and until the digits enter the queue.
// Output: one character per cycle on ascii_char, marked by strobe; the sign '-'
// comes first for a negative value, then the digits, most significant first, and
// last is high on the final digit. The receiver cannot stall: a result is present
// for exactly one cycle.
// The first character follows the front end's conversion and push states, the queue
// entry and the back end's idle state, which pops the entry; a full queue holds the
// push and a back end still emitting holds the pop. The front end does one reciprocal
// multiply per digit and takes no new value until it has pushed the last one; the
// two-entry queue lets the front and back ends run at once, and the back end chains
// straight from one number to the next when one is waiting.
// Reset clears both state machines and empties the queue; no cleanup pass.
`timescale 1ns / 1ps

module int_to_decimal_ascii (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  value,
    output logic                strobe,
    output logic [6:0]          ascii_char,
    output logic                last
);
    import itda_pkg::*;

    queue_status_t  q_status;
    conv_entry_t    push_entry;
    conv_entry_t    head;
    logic           push;
    logic           pop;

    itda_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value      (value),
        .busy       (busy),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    itda_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    itda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head       (head),
        .pop        (pop),
        .strobe     (strobe),
        .ascii_char (ascii_char),
        .last       (last)
    );

endmodule
